// ----- hdl/bcu_pkg.sv -----
package bcu_pkg;

  // Width of the quotient and remainder in the restoring dividers.
  localparam int DivWidth = 32;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_OVERSAMPLING = 3'd0,
    REG_COEFF_A1     = 3'd1,
    REG_COEFF_A2     = 3'd2,
    REG_COEFF_A3     = 3'd3,
    REG_COEFF_A4     = 3'd4,
    REG_GAIN_OFFSET  = 3'd5,
    REG_CURVE_PAIR   = 3'd6,
    REG_SQUARE_PAIR  = 3'd7
  } reg_index_t;

  // Reset values of the calibration registers.
  localparam logic [1:0]  RST_OVERSAMPLING = 2'd0;
  localparam logic [15:0] RST_COEFF_A1     = 16'd408;
  localparam logic [15:0] RST_COEFF_A2     = 16'hFFB8;
  localparam logic [15:0] RST_COEFF_A3     = 16'hC7D1;
  localparam logic [15:0] RST_COEFF_A4     = 16'd32741;
  localparam logic [31:0] RST_GAIN_OFFSET  = 32'd2146785905;
  localparam logic [31:0] RST_CURVE_PAIR   = 32'd3724086068;
  localparam logic [31:0] RST_SQUARE_PAIR  = 32'd405667844;

  // Fixed terms of the compensation formulas.
  localparam logic [31:0] TEMP_OFFSET    = 32'd4000;
  localparam logic [31:0] B4_BIAS        = 32'd32768;
  localparam logic [31:0] B7_SCALE       = 32'd50000;
  localparam logic [31:0] P_SQUARE_GAIN  = 32'd3038;
  localparam logic [31:0] P_LINEAR_GAIN  = 32'hFFFFE343;  // -7357
  localparam logic [31:0] P_BIAS         = 32'd3791;
  localparam logic [31:0] PRESSURE_MAX   = 32'd1048575;

  // Side information that rides along with a division.
  typedef struct packed {
    logic        fault;
    logic        flag;   // negate the quotient, or double it
    logic [18:0] up;
    logic [31:0] word;
  } div_side_t;

  // Sign-extends a 16-bit word to 32 bits.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ----- hdl/bcu_div.sv -----
// Unsigned restoring divider, one quotient bit per pipeline stage.
module bcu_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [31:0]              dividend,
  input  logic [31:0]              divisor,
  input  bcu_pkg::div_side_t       in_side,
  output logic                     out_valid,
  output logic [31:0]              quotient,
  output bcu_pkg::div_side_t       out_side
);

  localparam int N = bcu_pkg::DivWidth;

  logic                 vld  [1:N];
  logic [N-1:0]         rem  [1:N];
  logic [N-1:0]         quo  [1:N];
  logic [N-1:0]         num  [1:N];
  logic [N-1:0]         den  [1:N];
  bcu_pkg::div_side_t   side [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic               v_in;
    logic [N-1:0]       r_in;
    logic [N-1:0]       q_in;
    logic [N-1:0]       n_in;
    logic [N-1:0]       d_in;
    bcu_pkg::div_side_t s_in;
    logic [N:0]         trial;
    logic [N:0]         diff;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = dividend;
      assign d_in = divisor;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[i];
      assign r_in = rem[i];
      assign q_in = quo[i];
      assign n_in = num[i];
      assign d_in = den[i];
      assign s_in = side[i];
    end

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {r_in, n_in[N-1-i]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= diff[N] ? trial[N-1:0] : diff[N-1:0];
        quo[i+1]  <= {q_in[N-2:0], ~diff[N]};
        num[i+1]  <= n_in;
        den[i+1]  <= d_in;
        side[i+1] <= s_in;
      end
    end
  end

  assign out_valid = vld[N];
  assign quotient  = quo[N];
  assign out_side  = side[N];

endmodule

// ----- hdl/barometer_compensation_unit.sv -----
// Compensates one raw temperature and pressure reading pair per cycle. The
// datapath is a 77-stage pipeline: three stages for the temperature product,
// a 32-stage divider for the temperature term, six stages of pressure
// polynomials, a second 32-stage divider for the pressure quotient and four
// final stages; a new pair enters every cycle while the output side is not
// stalled. A zero divisor sets divide_fault and forces both results to zero.
// The user must write the calibration registers only while no reading is in
// flight; the block itself does not enforce this.
module barometer_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // temperature_tenths[15:0], pressure_pascal[35:16],
                                 // divide_fault[36], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Calibration registers.
  logic [1:0]  oversampling_mode;
  logic [15:0] coeff_a1;
  logic [15:0] coeff_a2;
  logic [15:0] coeff_a3;
  logic [15:0] coeff_a4;
  logic [31:0] temp_gain_offset;
  logic [31:0] temp_curve_pair;
  logic [31:0] square_term_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversampling_mode <= bcu_pkg::RST_OVERSAMPLING;
      coeff_a1          <= bcu_pkg::RST_COEFF_A1;
      coeff_a2          <= bcu_pkg::RST_COEFF_A2;
      coeff_a3          <= bcu_pkg::RST_COEFF_A3;
      coeff_a4          <= bcu_pkg::RST_COEFF_A4;
      temp_gain_offset  <= bcu_pkg::RST_GAIN_OFFSET;
      temp_curve_pair   <= bcu_pkg::RST_CURVE_PAIR;
      square_term_pair  <= bcu_pkg::RST_SQUARE_PAIR;
    end else if (cfg_we) begin
      case (bcu_pkg::reg_index_t'(cfg_index))
        bcu_pkg::REG_OVERSAMPLING: oversampling_mode <= cfg_data[1:0];
        bcu_pkg::REG_COEFF_A1:     coeff_a1          <= cfg_data[15:0];
        bcu_pkg::REG_COEFF_A2:     coeff_a2          <= cfg_data[15:0];
        bcu_pkg::REG_COEFF_A3:     coeff_a3          <= cfg_data[15:0];
        bcu_pkg::REG_COEFF_A4:     coeff_a4          <= cfg_data[15:0];
        bcu_pkg::REG_GAIN_OFFSET:  temp_gain_offset  <= cfg_data;
        bcu_pkg::REG_CURVE_PAIR:   temp_curve_pair   <= cfg_data;
        bcu_pkg::REG_SQUARE_PAIR:  square_term_pair  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sign-extended calibration words.
  logic [31:0] ac1, ac2, ac3, mc, md, b1, b2;
  assign ac1 = bcu_pkg::sx16(coeff_a1);
  assign ac2 = bcu_pkg::sx16(coeff_a2);
  assign ac3 = bcu_pkg::sx16(coeff_a3);
  assign mc  = bcu_pkg::sx16(temp_curve_pair[31:16]);
  assign md  = bcu_pkg::sx16(temp_curve_pair[15:0]);
  assign b1  = bcu_pkg::sx16(square_term_pair[31:16]);
  assign b2  = bcu_pkg::sx16(square_term_pair[15:0]);

  // The whole pipeline moves when the output register is free or drained.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: capture the input transfer.
  logic        v1;
  logic [15:0] ut1;
  logic [18:0] up1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ut1 <= s_tdata[15:0];
      up1 <= s_tdata[34:16];
    end
  end

  // Stage 2: (UT - AC6) * AC5.
  logic        v2;
  logic [31:0] pt2;
  logic [18:0] up2;
  logic [31:0] dt;
  logic [47:0] pt_full;
  assign dt      = {16'h0, ut1} - {16'h0, temp_gain_offset[15:0]};
  assign pt_full = dt * temp_gain_offset[31:16];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pt2 <= pt_full[31:0];
      up2 <= up1;
    end
  end

  // Stage 3: X1 and the temperature divisor X1 + MD.
  logic        v3;
  logic [31:0] x1_3, den3;
  logic [18:0] up3;
  logic [31:0] x1_t;
  assign x1_t = $signed(pt2) >>> 15;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1_3 <= x1_t;
      den3 <= x1_t + md;
      up3  <= up2;
    end
  end

  // Signed division MC * 2048 / (X1 + MD) on magnitudes.
  logic [31:0]        num_abs, den_abs;
  bcu_pkg::div_side_t side1_in, side1_out;
  logic               dv1;
  logic [31:0]        q1;
  assign num_abs = mc[31] ? (32'h0 - {mc[20:0], 11'h0}) : {mc[20:0], 11'h0};
  assign den_abs = den3[31] ? (32'h0 - den3) : den3;
  always_comb begin
    side1_in.fault = (den3 == 32'h0);
    side1_in.flag  = mc[31] ^ den3[31];
    side1_in.up    = up3;
    side1_in.word  = x1_3;
  end

  bcu_div u_div_temp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .dividend  (num_abs),
    .divisor   (den_abs),
    .in_side   (side1_in),
    .out_valid (dv1),
    .quotient  (q1),
    .out_side  (side1_out)
  );

  // Stage 5: B5 = X1 + X2.
  logic        v5, f5;
  logic [31:0] b5_5;
  logic [18:0] up5;
  logic [31:0] x2_t;
  assign x2_t = side1_out.flag ? (32'h0 - q1) : q1;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= dv1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b5_5 <= side1_out.word + x2_t;
      up5  <= side1_out.up;
      f5   <= side1_out.fault;
    end
  end

  // Stage 6: B6 and its products.
  logic        v6, f6;
  logic [31:0] b5_6, b6sq6, ac2b6_6, ac3b6_6;
  logic [18:0] up6;
  logic [31:0] b6;
  logic [63:0] m_b6b6, m_ac2, m_ac3;
  assign b6     = b5_5 - bcu_pkg::TEMP_OFFSET;
  assign m_b6b6 = b6 * b6;
  assign m_ac2  = ac2 * b6;
  assign m_ac3  = ac3 * b6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b6sq6   <= m_b6b6[31:0];
      ac2b6_6 <= m_ac2[31:0];
      ac3b6_6 <= m_ac3[31:0];
      b5_6    <= b5_5;
      up6     <= up5;
      f6      <= f5;
    end
  end

  // Stage 7: scaled square and the B1, B2 products.
  logic        v7, f7;
  logic [31:0] b5_7, x2a7, x1b7, b2sq7, b1sq7;
  logic [18:0] up7;
  logic [31:0] sq;
  logic [63:0] m_b2, m_b1;
  assign sq   = $signed(b6sq6) >>> 12;
  assign m_b2 = b2 * sq;
  assign m_b1 = b1 * sq;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x2a7  <= $signed(ac2b6_6) >>> 11;
      x1b7  <= $signed(ac3b6_6) >>> 13;
      b2sq7 <= m_b2[31:0];
      b1sq7 <= m_b1[31:0];
      b5_7  <= b5_6;
      up7   <= up6;
      f7    <= f6;
    end
  end

  // Stage 8: B3 and the B4 factor.
  logic        v8, f8;
  logic [31:0] b5_8, b3_8, t8;
  logic [18:0] up8;
  logic [31:0] b2sq_sh, b1sq_sh;
  logic [31:0] x3a, b3_sum, b3_shift, b3_round, x3b_sum, x3b;
  // The arithmetic shifts stand alone so the unsigned sums keep their sign fill.
  assign b2sq_sh  = $signed(b2sq7) >>> 11;
  assign b1sq_sh  = $signed(b1sq7) >>> 16;
  assign x3a      = b2sq_sh + x2a7;
  assign b3_sum   = {ac1[29:0], 2'b00} + x3a;
  assign b3_shift = b3_sum << oversampling_mode;
  assign b3_round = b3_shift + 32'd2;
  assign x3b_sum  = x1b7 + b1sq_sh + 32'd2;
  assign x3b      = $signed(x3b_sum) >>> 2;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // Signed divide by four, truncating toward zero.
      b3_8 <= $signed(b3_round + (b3_round[31] ? 32'd3 : 32'd0)) >>> 2;
      t8   <= x3b + bcu_pkg::B4_BIAS;
      b5_8 <= b5_7;
      up8  <= up7;
      f8   <= f7;
    end
  end

  // Stage 9: AC4 product and UP - B3.
  logic        v9, f9;
  logic [31:0] b5_9, b4p9, diff9;
  logic [47:0] m_ac4;
  assign m_ac4 = t8 * coeff_a4;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4p9  <= m_ac4[31:0];
      diff9 <= {13'h0, up8} - b3_8;
      b5_9  <= b5_8;
      f9    <= f8;
    end
  end

  // Stage 10: B4 and B7.
  logic        v10, f10;
  logic [31:0] b5_10, b4_10, b7_10;
  logic [31:0] b7_scale;
  logic [47:0] m_b7;
  assign b7_scale = bcu_pkg::B7_SCALE >> oversampling_mode;
  assign m_b7     = diff9 * b7_scale[15:0];
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4_10 <= b4p9 >> 15;
      b7_10 <= m_b7[31:0];
      b5_10 <= b5_9;
      f10   <= f9;
    end
  end

  // Pressure quotient: small B7 is doubled first, large B7 afterwards.
  bcu_pkg::div_side_t side2_in, side2_out;
  logic               dv2;
  logic [31:0]        q2;
  logic [31:0]        dividend2;
  assign dividend2 = b7_10[31] ? b7_10 : {b7_10[30:0], 1'b0};
  always_comb begin
    side2_in.fault = f10 || (b4_10 == 32'h0);
    side2_in.flag  = b7_10[31];
    side2_in.up    = '0;
    side2_in.word  = b5_10;
  end

  bcu_div u_div_pres (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v10),
    .dividend  (dividend2),
    .divisor   (b4_10),
    .in_side   (side2_in),
    .out_valid (dv2),
    .quotient  (q2),
    .out_side  (side2_out)
  );

  // Stage 11: pressure before the final correction.
  logic        v11, f11;
  logic [31:0] p11, b5_11;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= dv2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p11   <= side2_out.flag ? {q2[30:0], 1'b0} : q2;
      b5_11 <= side2_out.word;
      f11   <= side2_out.fault;
    end
  end

  // Stage 12: square of P / 256 and the linear term.
  logic        v12, f12;
  logic [31:0] p12, b5_12, psq12, plin12;
  logic [31:0] pa;
  logic [63:0] m_psq, m_plin;
  assign pa     = $signed(p11) >>> 8;
  assign m_psq  = pa * pa;
  assign m_plin = bcu_pkg::P_LINEAR_GAIN * p11;
  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      psq12  <= m_psq[31:0];
      plin12 <= m_plin[31:0];
      p12    <= p11;
      b5_12  <= b5_11;
      f12    <= f11;
    end
  end

  // Stage 13: square term gain.
  logic        v13, f13;
  logic [31:0] p13, b5_13, psg13, x2p13;
  logic [63:0] m_psg;
  assign m_psg = psq12 * bcu_pkg::P_SQUARE_GAIN;
  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (en) v13 <= v12;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      psg13 <= m_psg[31:0];
      x2p13 <= $signed(plin12) >>> 16;
      p13   <= p12;
      b5_13 <= b5_12;
      f13   <= f12;
    end
  end

  // Stage 14: final correction, saturation and the output register.
  logic [31:0] psg_sh, corr_sh;
  logic [31:0] corr_sum, p_final, t_wide;
  logic [19:0] pres_sat;
  logic [15:0] temp_sat;
  logic [31:0] b5_round;
  assign psg_sh   = $signed(psg13) >>> 16;
  assign corr_sum = psg_sh + x2p13 + bcu_pkg::P_BIAS;
  assign corr_sh  = $signed(corr_sum) >>> 4;
  assign p_final  = p13 + corr_sh;
  assign b5_round = b5_13 + 32'd8;
  assign t_wide   = $signed(b5_round) >>> 4;

  always_comb begin
    if (p_final[31]) begin
      pres_sat = '0;
    end else if (p_final > bcu_pkg::PRESSURE_MAX) begin
      pres_sat = bcu_pkg::PRESSURE_MAX[19:0];
    end else begin
      pres_sat = p_final[19:0];
    end
    if ($signed(t_wide) > $signed(32'sd32767)) begin
      temp_sat = 16'h7FFF;
    end else if ($signed(t_wide) < $signed(-32'sd32768)) begin
      temp_sat = 16'h8000;
    end else begin
      temp_sat = t_wide[15:0];
    end
  end

  logic [15:0] temperature_tenths;
  logic [19:0] pressure_pascal;
  logic        divide_fault;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v13;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      temperature_tenths <= f13 ? 16'h0 : temp_sat;
      pressure_pascal    <= f13 ? 20'h0 : pres_sat;
      divide_fault       <= f13;
    end
  end

  assign m_tdata = {3'b000, divide_fault, pressure_pascal, temperature_tenths};

endmodule

// ----- hdl/bcu_checker.sv -----
// Port-level checks of the compensation unit.
module bcu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A faulted result carries zero temperature and pressure.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36] |-> m_tdata[35:0] == 36'h0)
    else $error("faulted result has nonzero fields");

  // A stalled result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The input side is never blocked while the output side drains.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:37] == 3'b000)
    else $error("nonzero padding in result");

endmodule

bind barometer_compensation_unit bcu_checker u_bcu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/barometer_compensation_unit_tb.sv -----
module barometer_compensation_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 77;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [18:0] raw_pressure;
    logic [15:0] raw_temperature;
  } reading_t;

  typedef struct packed {
    logic        divide_fault;
    logic [19:0] pressure_pascal;
    logic [15:0] temperature_tenths;
  } compensated_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Calibration shadow copy used by the predictor.
  logic [1:0]  os_mode;
  logic [15:0] ac1_w, ac2_w, ac3_w, ac4_w;
  logic [31:0] gain_offset_w, curve_pair_w, square_pair_w;

  reading_t     pending_readings[$];
  compensated_t expected_results[$];
  int           fail_count = 0;
  int           result_count = 0;
  int           fault_count = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_phase = 0;
  bit           hold_sender = 1'b0;
  bit           in_accepted = 1'b0;

  barometer_compensation_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shr_arith(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // Computes the compensated temperature and pressure for one reading pair.
  function automatic compensated_t compensate(input reading_t rd);
    compensated_t res;
    logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
    logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
    longint t, pv;
    ut = {16'd0, rd.raw_temperature};
    up = {13'd0, rd.raw_pressure};
    ac1 = sext16(ac1_w);
    ac2 = sext16(ac2_w);
    ac3 = sext16(ac3_w);
    ac4 = {16'd0, ac4_w};
    ac5 = {16'd0, gain_offset_w[31:16]};
    ac6 = {16'd0, gain_offset_w[15:0]};
    mc = sext16(curve_pair_w[31:16]);
    md = sext16(curve_pair_w[15:0]);
    b1 = sext16(square_pair_w[31:16]);
    b2 = sext16(square_pair_w[15:0]);
    res = '0;
    res.divide_fault = 1'b1;
    x1 = shr_arith((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return res;
    x2 = $unsigned(32'(($signed(mc) * 64'sd2048) / $signed(den)));
    b5 = x1 + x2;
    b6 = b5 - 32'd4000;
    sq = shr_arith(b6 * b6, 12);
    x1 = shr_arith(b2 * sq, 11);
    x2 = shr_arith(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = ((ac1 * 32'd4 + x3) << os_mode) + 32'd2;
    b3 = $unsigned($signed(b3) / 32'sd4);
    x1 = shr_arith(ac3 * b6, 13);
    x2 = shr_arith(b1 * sq, 16);
    x3 = shr_arith(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return res;
    b7 = (up - b3) * (32'd50000 >> os_mode);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = shr_arith(p, 8);
    x1 = x1 * x1;
    x1 = shr_arith(x1 * 32'd3038, 16);
    x2 = shr_arith(32'hFFFFE343 * p, 16);
    p = p + shr_arith(x1 + x2 + 32'd3791, 4);
    t = longint'($signed(shr_arith(b5 + 32'd8, 4)));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    pv = longint'($signed(p));
    if (pv < 0) pv = 0;
    if (pv > 1048575) pv = 1048575;
    res.temperature_tenths = t[15:0];
    res.pressure_pascal = pv[19:0];
    res.divide_fault = 1'b0;
    return res;
  endfunction

  // Writes one calibration register and mirrors it in the shadow copy.
  task automatic write_reg(input bcu_pkg::reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      bcu_pkg::REG_OVERSAMPLING: os_mode = value[1:0];
      bcu_pkg::REG_COEFF_A1:     ac1_w = value[15:0];
      bcu_pkg::REG_COEFF_A2:     ac2_w = value[15:0];
      bcu_pkg::REG_COEFF_A3:     ac3_w = value[15:0];
      bcu_pkg::REG_COEFF_A4:     ac4_w = value[15:0];
      bcu_pkg::REG_GAIN_OFFSET:  gain_offset_w = value;
      bcu_pkg::REG_CURVE_PAIR:   curve_pair_w = value;
      default:                   square_pair_w = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_reading(input logic [15:0] ut, input logic [18:0] up);
    reading_t rd;
    rd.raw_temperature = ut;
    rd.raw_pressure = up;
    pending_readings.push_back(rd);
  endtask

  // Waits until the pipeline has drained every queued and expected reading.
  task automatic drain_pipeline();
    wait (pending_readings.size() == 0 && expected_results.size() == 0);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic load_defaults();
    write_reg(bcu_pkg::REG_OVERSAMPLING, 32'd0);
    write_reg(bcu_pkg::REG_COEFF_A1, 32'd408);
    write_reg(bcu_pkg::REG_COEFF_A2, 32'h0000FFB8);
    write_reg(bcu_pkg::REG_COEFF_A3, 32'h0000C7D1);
    write_reg(bcu_pkg::REG_COEFF_A4, 32'd32741);
    write_reg(bcu_pkg::REG_GAIN_OFFSET, 32'd2146785905);
    write_reg(bcu_pkg::REG_CURVE_PAIR, 32'd3724086068);
    write_reg(bcu_pkg::REG_SQUARE_PAIR, 32'd405667844);
  endtask

  task automatic queue_random(input int count, input bit realistic);
    for (int i = 0; i < count; i++) begin
      if (realistic)
        queue_reading(16'($urandom_range(35000, 20000)), 19'($urandom_range(60000, 20000)));
      else
        queue_reading(16'($urandom), 19'($urandom));
    end
  endtask

  // Driver: sends pending readings in bursts separated by random gaps.
  // The previous item is known to be taken from the flag set at the rising edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_accepted) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(40, 1);
        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
      end
      if (gap_left > 0 && burst_left == 0) gap_left--;
      if (!hold_sender && pending_readings.size() > 0 && burst_left > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, pending_readings[0].raw_pressure,
                    pending_readings[0].raw_temperature};
        burst_left--;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: long open stretches mixed with random stalls.
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 300;
    if (rst) m_tready <= 1'b0;
    else if (stall_phase < 100) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(3, 0) != 0);
  end

  // Predictor and checker: expectations on input transfers, compare on output transfers.
  always @(posedge clk) begin
    compensated_t got, want;
    in_accepted = s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(compensate(reading_t'(s_tdata[34:0])));
        void'(pending_readings.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got = compensated_t'(m_tdata[36:0]);
        result_count++;
        if (got.divide_fault) fault_count++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.temperature_tenths !== want.temperature_tenths) begin
            $error("temperature_tenths expected %0d actual %0d",
                   $signed(want.temperature_tenths), $signed(got.temperature_tenths));
            fail_count++;
          end
          if (got.pressure_pascal !== want.pressure_pascal) begin
            $error("pressure_pascal expected %0d actual %0d",
                   want.pressure_pascal, got.pressure_pascal);
            fail_count++;
          end
          if (got.divide_fault !== want.divide_fault) begin
            $error("divide_fault expected %0b actual %0b",
                   want.divide_fault, got.divide_fault);
            fail_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
      else if (expected_results.size() > 0 || pending_readings.size() > 0) idle_cycles++;
      else idle_cycles = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    os_mode = bcu_pkg::RST_OVERSAMPLING;
    ac1_w = bcu_pkg::RST_COEFF_A1;
    ac2_w = bcu_pkg::RST_COEFF_A2;
    ac3_w = bcu_pkg::RST_COEFF_A3;
    ac4_w = bcu_pkg::RST_COEFF_A4;
    gain_offset_w = bcu_pkg::RST_GAIN_OFFSET;
    curve_pair_w = bcu_pkg::RST_CURVE_PAIR;
    square_pair_w = bcu_pkg::RST_SQUARE_PAIR;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed readings at reset calibration: field extremes and typical values.
    queue_reading(16'd0, 19'd0);
    queue_reading(16'hFFFF, 19'h7FFFF);
    queue_reading(16'd0, 19'h7FFFF);
    queue_reading(16'hFFFF, 19'd0);
    queue_reading(16'd27898, 19'd23843);
    queue_reading(16'h5555, 19'h2AAAA);
    queue_reading(16'hAAAA, 19'h55555);
    drain_pipeline();

    // Zero temperature divisor: AC6 = UT with MD = 0 gives X1 + MD = 0.
    write_reg(bcu_pkg::REG_CURVE_PAIR, 32'hD4A20000);
    write_reg(bcu_pkg::REG_GAIN_OFFSET, 32'h7FF51234);
    queue_reading(16'h1234, 19'd30000);
    queue_reading(16'h1235, 19'd30000);
    drain_pipeline();

    // Zero pressure divisor: AC4 = 0 forces B4 to zero; large B7 with negative B3.
    load_defaults();
    write_reg(bcu_pkg::REG_COEFF_A4, 32'd0);
    queue_reading(16'd27898, 19'd23843);
    drain_pipeline();
    write_reg(bcu_pkg::REG_COEFF_A4, 32'd1);
    write_reg(bcu_pkg::REG_COEFF_A1, 32'h00008000);
    write_reg(bcu_pkg::REG_OVERSAMPLING, 32'd3);
    queue_reading(16'd27898, 19'h7FFFF);
    queue_reading(16'd27898, 19'd0);
    drain_pipeline();

    // Extreme calibration words, then random phases across settings.
    write_reg(bcu_pkg::REG_COEFF_A1, 32'h00007FFF);
    write_reg(bcu_pkg::REG_COEFF_A2, 32'h00008000);
    write_reg(bcu_pkg::REG_COEFF_A3, 32'h00007FFF);
    write_reg(bcu_pkg::REG_COEFF_A4, 32'h0000FFFF);
    write_reg(bcu_pkg::REG_GAIN_OFFSET, 32'hFFFFFFFF);
    write_reg(bcu_pkg::REG_CURVE_PAIR, 32'h80007FFF);
    write_reg(bcu_pkg::REG_SQUARE_PAIR, 32'h7FFF8000);
    queue_random(10, 1'b0);
    drain_pipeline();

    for (int phase = 0; phase < 8; phase++) begin
      load_defaults();
      write_reg(bcu_pkg::REG_OVERSAMPLING, 32'(phase % 4));
      if (phase >= 4) begin
        write_reg(bcu_pkg::REG_COEFF_A1, $urandom);
        write_reg(bcu_pkg::REG_COEFF_A2, $urandom);
        write_reg(bcu_pkg::REG_COEFF_A3, $urandom);
        write_reg(bcu_pkg::REG_COEFF_A4, $urandom);
        write_reg(bcu_pkg::REG_GAIN_OFFSET, $urandom);
        write_reg(bcu_pkg::REG_CURVE_PAIR, $urandom);
        write_reg(bcu_pkg::REG_SQUARE_PAIR, $urandom);
      end
      queue_random(180, 1'b1);
      queue_random(70, 1'b0);
      if (phase == 2) begin
        // Sender holds off until every outstanding result has arrived.
        wait (pending_readings.size() <= 125);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        hold_sender = 1'b0;
      end
      drain_pipeline();
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d compensated results (%0d divide faults) over all four",
             result_count, fault_count);
    $display("oversampling modes with reset, extreme and random calibration.");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
